[hw/rtl/tonm_pkg.sv]
`timescale 1ns / 1ps
// Shared types, byte codes and helpers for the telnet option refuser and matcher.
// No dependencies; every other file in hw/rtl refers to this package by scoped names.

package tonm_pkg;

    // Telnet command bytes and text characters the block reacts to
    localparam logic [7:0] BYTE_IAC  = 8'd255;
    localparam logic [7:0] BYTE_DONT = 8'd254;
    localparam logic [7:0] BYTE_DO   = 8'd253;
    localparam logic [7:0] BYTE_WONT = 8'd252;
    localparam logic [7:0] BYTE_WILL = 8'd251;
    localparam logic [7:0] BYTE_SB   = 8'd250;
    localparam logic [7:0] BYTE_SE   = 8'd240;
    localparam logic [7:0] BYTE_CR   = 8'd13;
    localparam logic [7:0] BYTE_GT   = 8'd62;
    localparam logic [7:0] BYTE_SP   = 8'd32;

    // Needle storage: two 64-bit registers hold up to 16 characters
    localparam int NEEDLE_MAX_DEF = 16;
    localparam int NEEDLE_CHARS   = 16;
    localparam int NEEDLE_LEN_W   = 5;
    localparam int CFG_DATA_W     = 64;
    localparam int CFG_INDEX_W    = 8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_MATCH_MODE   = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LOW   = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_HIGH  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_NEEDLE_LEN   = 8'd3;

    // IAC parser states
    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_IAC      = 3'd1,
        ST_OPT_ACK  = 3'd2,
        ST_OPT_DROP = 3'd3,
        ST_SUB      = 3'd4,
        ST_SUB_IAC  = 3'd5
    } t_parse_state;

    // Per-byte result of the parser, consumed by the matcher and the output register
    typedef struct packed {
        logic       data_valid;
        logic [7:0] data_byte;
        logic       reply_valid;
        logic       reply_refuse_do;
        logic [7:0] reply_option;
        logic       push;
        logic [7:0] push_byte;
    } t_parse_res;

    // Lowercase A-Z only
    function automatic logic [7:0] lower_ascii(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'd65 && c <= 8'd90) begin
            r = c + 8'd32;
        end
        return r;
    endfunction

endpackage

[hw/rtl/telnet_option_refuser_and_matcher.sv]
`timescale 1ns / 1ps
// Top level: configuration registers, parser and matcher, and the result register.
// Depends on tonm_pkg, tonm_parser and tonm_matcher.
//
// Usage
//   Input channel: one received telnet byte per transaction on i_rx_byte,
//   qualified by i_in_valid and held off by o_in_stall.
//   Output channel: one result per input byte (data byte, refusal reply,
//   found flag), qualified by o_out_valid and held off by i_out_stall.
//   Configuration: i_cfg_valid with i_cfg_index / i_cfg_data; o_cfg_ready is
//   always high. Write only while no byte is in flight.
//   Result: the result of a byte is registered and presented in the cycle after it is accepted.
//   Throughput: one byte per cycle when not stalled; parse, window shift and
//   the 16 parallel needle compares all sit between parser state and result register.
//   Stall: the result register holds while i_out_stall is high; a new byte is
//   still taken in the same cycle the held result is taken, and o_in_stall
//   rises only when a result is held and the receiver stalls.
//   Reset: parser returns to plain data, tail window fills with zero bytes,
//   the needle flag and all configuration registers clear, no result pending.

module telnet_option_refuser_and_matcher #(
    parameter int NEEDLE_MAX = tonm_pkg::NEEDLE_MAX_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [7:0]                       i_rx_byte,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_data_valid,
    output logic [7:0]                       o_data_byte,
    output logic                             o_reply_valid,
    output logic                             o_reply_refuse_do,
    output logic [7:0]                       o_reply_option,
    output logic                             o_found,
    // configuration write channel
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tonm_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [tonm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                              r_match_mode;
    logic [tonm_pkg::CFG_DATA_W-1:0]   r_needle_low;
    logic [tonm_pkg::CFG_DATA_W-1:0]   r_needle_high;
    logic [tonm_pkg::NEEDLE_LEN_W-1:0] r_needle_length;

    logic                              w_accept;
    tonm_pkg::t_parse_res              w_res;
    logic                              w_found;

    logic                              r_out_valid;
    logic                              r_data_valid;
    logic [7:0]                        r_data_byte;
    logic                              r_reply_valid;
    logic                              r_reply_refuse_do;
    logic [7:0]                        r_reply_option;
    logic                              r_found;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_mode    <= 1'b0;
            r_needle_low    <= '0;
            r_needle_high   <= '0;
            r_needle_length <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tonm_pkg::CFG_MATCH_MODE:  r_match_mode    <= i_cfg_data[0];
                tonm_pkg::CFG_NEEDLE_LOW:  r_needle_low    <= i_cfg_data;
                tonm_pkg::CFG_NEEDLE_HIGH: r_needle_high   <= i_cfg_data;
                tonm_pkg::CFG_NEEDLE_LEN:
                    r_needle_length <= i_cfg_data[tonm_pkg::NEEDLE_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Input handshake: blocked only when a held result is stalled
    assign o_in_stall = r_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    tonm_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_res     (w_res)
    );

    tonm_matcher #(
        .NEEDLE_MAX (NEEDLE_MAX)
    ) u_matcher (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_advance       (w_accept),
        .i_push          (w_res.push),
        .i_push_byte     (w_res.push_byte),
        .i_match_mode    (r_match_mode),
        .i_needle_low    (r_needle_low),
        .i_needle_high   (r_needle_high),
        .i_needle_length (r_needle_length),
        .o_found         (w_found)
    );

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_data_valid      <= w_res.data_valid;
            r_data_byte       <= w_res.data_byte;
            r_reply_valid     <= w_res.reply_valid;
            r_reply_refuse_do <= w_res.reply_refuse_do;
            r_reply_option    <= w_res.reply_option;
            r_found           <= w_found;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_data_valid      = r_data_valid;
    assign o_data_byte       = r_data_byte;
    assign o_reply_valid     = r_reply_valid;
    assign o_reply_refuse_do = r_reply_refuse_do;
    assign o_reply_option    = r_reply_option;
    assign o_found           = r_found;

`ifndef NO_ASSERTIONS
    // a byte is either data or a reply trigger, never both
    a_data_xor_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_data_valid && o_reply_valid))
        else $error("data and reply flagged for one byte");

    // reply fields are zero when no reply is due
    a_reply_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_reply_valid |-> (o_reply_option == 8'd0) && !o_reply_refuse_do)
        else $error("reply fields set without reply");

    // every accepted transaction yields a pending result on the next cycle
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted byte produced no result");
`endif

endmodule

[hw/rtl/tonm_parser.sv]
`timescale 1ns / 1ps
// Telnet IAC parser: command state machine and refusal reply generation.
// Depends on tonm_pkg.

module tonm_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  logic [7:0]           i_rx_byte,
    output tonm_pkg::t_parse_res o_res
);

    tonm_pkg::t_parse_state r_state, n_state;
    logic                   r_pending_will, n_pending_will;

    // State register, moves only on an accepted transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tonm_pkg::ST_DATA;
            r_pending_will <= 1'b0;
        end else if (i_advance) begin
            r_state        <= n_state;
            r_pending_will <= n_pending_will;
        end
    end

    // Next state and per-byte outputs
    always_comb begin
        n_state        = r_state;
        n_pending_will = r_pending_will;
        o_res          = '0;
        case (r_state)
            tonm_pkg::ST_IAC: begin
                if (i_rx_byte == tonm_pkg::BYTE_IAC) begin
                    // escaped IAC is data
                    o_res.data_valid = 1'b1;
                    o_res.data_byte  = tonm_pkg::BYTE_IAC;
                    n_state          = tonm_pkg::ST_DATA;
                end else if (i_rx_byte inside {tonm_pkg::BYTE_WILL, tonm_pkg::BYTE_DO}) begin
                    n_pending_will = (i_rx_byte == tonm_pkg::BYTE_WILL);
                    n_state        = tonm_pkg::ST_OPT_ACK;
                end else if (i_rx_byte inside {tonm_pkg::BYTE_WONT, tonm_pkg::BYTE_DONT}) begin
                    n_state = tonm_pkg::ST_OPT_DROP;
                end else if (i_rx_byte == tonm_pkg::BYTE_SB) begin
                    n_state = tonm_pkg::ST_SUB;
                end else begin
                    n_state = tonm_pkg::ST_DATA;
                end
            end
            tonm_pkg::ST_OPT_ACK: begin
                // WILL -> DONT, DO -> WONT
                o_res.reply_valid     = 1'b1;
                o_res.reply_refuse_do = ~r_pending_will;
                o_res.reply_option    = i_rx_byte;
                n_state               = tonm_pkg::ST_DATA;
            end
            tonm_pkg::ST_OPT_DROP: begin
                n_state = tonm_pkg::ST_DATA;
            end
            tonm_pkg::ST_SUB: begin
                if (i_rx_byte == tonm_pkg::BYTE_IAC) begin
                    n_state = tonm_pkg::ST_SUB_IAC;
                end
            end
            tonm_pkg::ST_SUB_IAC: begin
                // IAC IAC inside subnegotiation stays here
                if (i_rx_byte == tonm_pkg::BYTE_SE) begin
                    n_state = tonm_pkg::ST_DATA;
                end else if (i_rx_byte != tonm_pkg::BYTE_IAC) begin
                    n_state = tonm_pkg::ST_SUB;
                end
            end
            default: begin
                // plain data, also the fallback for unused codes
                if (i_rx_byte == tonm_pkg::BYTE_IAC) begin
                    n_state = tonm_pkg::ST_IAC;
                end else begin
                    o_res.data_valid = 1'b1;
                    o_res.data_byte  = i_rx_byte;
                    n_state          = tonm_pkg::ST_DATA;
                end
            end
        endcase
        // carriage return is data but stays out of the tail window
        o_res.push      = o_res.data_valid && (o_res.data_byte != tonm_pkg::BYTE_CR);
        o_res.push_byte = tonm_pkg::lower_ascii(o_res.data_byte);
    end

`ifndef NO_ASSERTIONS
    // an option byte after WILL/DO always returns the parser to plain data
    a_opt_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && r_state == tonm_pkg::ST_OPT_ACK |=> r_state == tonm_pkg::ST_DATA)
        else $error("parser did not return to data after option byte");
`endif

endmodule

[hw/rtl/tonm_matcher.sv]
`timescale 1ns / 1ps
// Tail window of recent data bytes with needle compare and prompt detection.
// Depends on tonm_pkg.

module tonm_matcher #(
    parameter int NEEDLE_MAX = tonm_pkg::NEEDLE_MAX_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_advance,
    input  logic                              i_push,
    input  logic [7:0]                        i_push_byte,
    input  logic                              i_match_mode,
    input  logic [tonm_pkg::CFG_DATA_W-1:0]   i_needle_low,
    input  logic [tonm_pkg::CFG_DATA_W-1:0]   i_needle_high,
    input  logic [tonm_pkg::NEEDLE_LEN_W-1:0] i_needle_length,
    output logic                              o_found
);

    // longest needle that can be compared
    localparam int NCMP = (NEEDLE_MAX < tonm_pkg::NEEDLE_CHARS) ? NEEDLE_MAX
                                                                 : tonm_pkg::NEEDLE_CHARS;

    logic [7:0]                            r_tail [NEEDLE_MAX];
    logic [7:0]                            n_tail [NEEDLE_MAX];
    logic                                  r_seen, n_seen;
    logic [tonm_pkg::NEEDLE_CHARS:0]       w_hit;
    logic [8*tonm_pkg::NEEDLE_CHARS-1:0]   w_needle;
    logic                                  w_len_ok;
    logic                                  w_needle_hit;
    logic                                  w_prompt;

    assign w_needle = {i_needle_high, i_needle_low};

    // Window shift: newest byte at the top index
    always_comb begin
        n_tail = r_tail;
        if (i_push) begin
            for (int k = 0; k < NEEDLE_MAX - 1; k++) begin
                n_tail[k] = r_tail[k+1];
            end
            n_tail[NEEDLE_MAX-1] = i_push_byte;
        end
    end

    // One compare per possible needle length, all in parallel
    always_comb begin
        w_hit = '0;
        for (int l = 1; l <= NCMP; l++) begin
            w_hit[l] = 1'b1;
            for (int j = 0; j < l; j++) begin
                if (n_tail[NEEDLE_MAX-l+j] != tonm_pkg::lower_ascii(w_needle[8*j +: 8])) begin
                    w_hit[l] = 1'b0;
                end
            end
        end
    end

    // zero length reads w_hit[0], which is always clear
    assign w_len_ok     = (i_needle_length <= tonm_pkg::NEEDLE_LEN_W'(tonm_pkg::NEEDLE_CHARS));
    assign w_needle_hit = w_len_ok ? w_hit[i_needle_length] : 1'b0;

    // prompt: ends in '>' or '> '
    assign w_prompt = (n_tail[NEEDLE_MAX-1] == tonm_pkg::BYTE_GT) ||
                      ((n_tail[NEEDLE_MAX-2] == tonm_pkg::BYTE_GT) &&
                       (n_tail[NEEDLE_MAX-1] == tonm_pkg::BYTE_SP));

    // sticky needle flag, only updated in needle mode
    assign n_seen  = r_seen | (~i_match_mode & w_needle_hit);
    assign o_found = i_match_mode ? w_prompt : n_seen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= 1'b0;
            for (int k = 0; k < NEEDLE_MAX; k++) begin
                r_tail[k] <= 8'd0;
            end
        end else if (i_advance) begin
            r_seen <= n_seen;
            r_tail <= n_tail;
        end
    end

endmodule
